>>> sv/swfr_pkg.sv
// swfr_pkg: codes and fixed widths for the sliding-window sender.
// No dependencies; compiled first.
`default_nettype none

package swfr_pkg;

  // item function codes
  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  // packet actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_NEW  = 2'd1;
  localparam logic [1:0] ACT_RETX = 2'd2;

  // timer commands
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // duplicate ack counter
  localparam int unsigned DUP_W     = 3;
  localparam logic [DUP_W-1:0] DUP_LIMIT = 3'd4;
  localparam logic [DUP_W-1:0] DUP_ONE   = 3'd1;

  // configuration
  localparam int unsigned WIN_W           = 5;
  localparam logic [WIN_W-1:0] WIN_RESET  = 5'd4;
  localparam int unsigned APB_AW          = 3;
  localparam int unsigned APB_DW          = 32;
  localparam logic REG_WIN_LIMIT          = 1'b0;   // register index, from paddr[2]

endpackage : swfr_pkg

`default_nettype wire

>>> sv/swfr_in_if.sv
// swfr_in_if / swfr_out_if: valid/ready channels of the sliding-window sender.
// Depends on nothing; widths set by parameters.
`default_nettype none

interface swfr_in_if #(
  parameter int unsigned SEQ_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic [PAYLOAD_BITS-1:0] payload_word;
  logic [SEQ_BITS-1:0]     ack_number;
  logic                    ack_checksum_good;

  modport source (output valid, func, payload_word, ack_number, ack_checksum_good,
                  input ready);
  modport sink   (input valid, func, payload_word, ack_number, ack_checksum_good,
                  output ready);
endinterface : swfr_in_if

interface swfr_out_if #(
  parameter int unsigned SEQ_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              packet_action;
  logic [SEQ_BITS-1:0]     packet_seq;
  logic [PAYLOAD_BITS-1:0] packet_payload;
  logic [1:0]              timer_command;
  logic [SEQ_BITS-1:0]     timer_seq;
  logic                    send_accepted;
  logic                    window_full;

  modport source (output valid, packet_action, packet_seq, packet_payload, timer_command,
                  timer_seq, send_accepted, window_full, input ready);
  modport sink   (input valid, packet_action, packet_seq, packet_payload, timer_command,
                  timer_seq, send_accepted, window_full, output ready);
endinterface : swfr_out_if

`default_nettype wire

>>> sv/sliding_window_sender_fast_retransmit.sv
// Sliding-window sender with fast retransmit. An accepted beat waits in stage 1 for its
// ring read, then moves to the output register. Throughput: one beat per cycle unless
// stage 1 and the skid entry are full; the payload ring is one synchronous RAM, one write
// and one read per cycle. A two-entry output buffer keeps in_ch ready while a result waits.
// Reset (rst_n low, synchronous): window limit 4, sequence numbers 1, counts and flags 0,
// pipeline empty; ring not cleared. Depends on swfr_pkg and the interfaces in swfr_in_if.sv.
`default_nettype none

module sliding_window_sender_fast_retransmit #(
  parameter int unsigned MAX_WINDOW   = 16,
  parameter int unsigned SEQ_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  swfr_in_if.sink                          in_ch,
  swfr_out_if.source                       out_ch,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [swfr_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [swfr_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [swfr_pkg::APB_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);

  // in-flight count must hold MAX_WINDOW itself
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned EW = (CW > swfr_pkg::WIN_W) ? CW : swfr_pkg::WIN_W;
  localparam int unsigned DW = (CW > SEQ_BITS) ? CW : SEQ_BITS;

  typedef struct packed {
    logic [1:0]              packet_action;
    logic [SEQ_BITS-1:0]     packet_seq;
    logic [PAYLOAD_BITS-1:0] packet_payload;
    logic [1:0]              timer_command;
    logic [SEQ_BITS-1:0]     timer_seq;
    logic                    send_accepted;
    logic                    window_full;
  } res_t;

  // ring index: (base + off) mod MAX_WINDOW, sum stays below 2*MAX_WINDOW
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(MAX_WINDOW)) begin
      sum = sum - (CW+1)'(MAX_WINDOW);
    end
    return sum[AW-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [swfr_pkg::WIN_W-1:0] window_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= swfr_pkg::WIN_RESET;
    end else if (cfg_wr && cfg_paddr[2] == swfr_pkg::REG_WIN_LIMIT) begin
      window_r <= cfg_pwdata[swfr_pkg::WIN_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == swfr_pkg::REG_WIN_LIMIT) begin
      cfg_prdata = swfr_pkg::APB_DW'(window_r);
    end
  end

  // ---------------- sender state ----------------
  logic [SEQ_BITS-1:0]        oldest_r, oldest_nxt;
  logic [SEQ_BITS-1:0]        next_seq_r, next_seq_nxt;
  logic [swfr_pkg::DUP_W-1:0] dup_r, dup_nxt;
  logic [CW-1:0]              inflight_r, inflight_nxt;
  logic                       waiting_r, waiting_nxt;
  logic [AW-1:0]              head_r, head_nxt;

  // stage 1: result waiting for the ring read data
  logic                    s1_v_r;
  res_t                    s1_res_r;
  logic                    s1_mem_r;     // payload comes from the ring
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  // output register and skid entry
  logic out_v_r, sk_v_r;
  res_t out_res_r, sk_res_r;

  logic                    in_ready;
  logic                    acc;
  res_t                    res;
  logic                    use_mem;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [EW-1:0]           eff_win;
  logic [SEQ_BITS-1:0]     ack_off;
  logic [swfr_pkg::DUP_W-1:0] dup_inc;
  logic [PAYLOAD_BITS-1:0] ring_mem [MAX_WINDOW];

  // stage 1 can always move on unless the skid entry is occupied
  assign in_ready    = !s1_v_r || !sk_v_r;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid & in_ready;

  // window sizes above MAX_WINDOW behave as MAX_WINDOW
  assign eff_win = (EW'(window_r) > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : EW'(window_r);
  assign ack_off = in_ch.ack_number - oldest_r;
  assign dup_inc = dup_r + swfr_pkg::DUP_ONE;

  always_comb begin
    oldest_nxt   = oldest_r;
    next_seq_nxt = next_seq_r;
    dup_nxt      = dup_r;
    inflight_nxt = inflight_r;
    waiting_nxt  = waiting_r;
    head_nxt     = head_r;
    res          = '0;
    use_mem      = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = slot_of(head_r, inflight_r);

    unique case (in_ch.func)
      swfr_pkg::FUNC_SEND: begin
        if (EW'(inflight_r) < eff_win) begin
          wr_en              = 1'b1;
          waiting_nxt        = 1'b0;
          res.packet_action  = swfr_pkg::ACT_NEW;
          res.packet_seq     = next_seq_r;
          res.packet_payload = in_ch.payload_word;
          res.send_accepted  = 1'b1;
          if (inflight_r == '0) begin
            // first packet in flight starts the timer
            res.timer_command = swfr_pkg::TMR_START;
            res.timer_seq     = next_seq_r;
          end
          inflight_nxt = inflight_r + CW'(1);
          next_seq_nxt = next_seq_r + SEQ_BITS'(1);
        end else begin
          waiting_nxt = 1'b1;
        end
      end
      swfr_pkg::FUNC_ACK: begin
        if (inflight_r != '0 && in_ch.ack_checksum_good &&
            DW'(ack_off) <= DW'(inflight_r)) begin
          if (ack_off == '0) begin
            // duplicate ack
            dup_nxt = dup_inc;
            if (dup_inc == swfr_pkg::DUP_LIMIT) begin
              use_mem           = 1'b1;
              res.packet_action = swfr_pkg::ACT_RETX;
              res.packet_seq    = oldest_r;
              res.timer_command = swfr_pkg::TMR_RESTART;
              res.timer_seq     = oldest_r;
              dup_nxt           = '0;
            end else if (dup_inc == swfr_pkg::DUP_ONE) begin
              res.timer_command = swfr_pkg::TMR_RESTART;
              res.timer_seq     = oldest_r;
            end
          end else begin
            // new ack slides the window
            dup_nxt      = swfr_pkg::DUP_ONE;
            oldest_nxt   = in_ch.ack_number;
            inflight_nxt = inflight_r - CW'(ack_off);
            head_nxt     = slot_of(head_r, CW'(ack_off));
            if (inflight_r == CW'(ack_off)) begin
              res.timer_command = swfr_pkg::TMR_STOP;
              res.timer_seq     = oldest_r;
            end else begin
              res.timer_command = swfr_pkg::TMR_RESTART;
              res.timer_seq     = in_ch.ack_number;
            end
          end
        end
      end
      swfr_pkg::FUNC_TIMEOUT: begin
        if (inflight_r != '0) begin
          use_mem           = 1'b1;
          res.packet_action = swfr_pkg::ACT_RETX;
          res.packet_seq    = oldest_r;
          res.timer_command = swfr_pkg::TMR_RESTART;
          res.timer_seq     = oldest_r;
        end
      end
      default: ;
    endcase

    res.window_full = waiting_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= SEQ_BITS'(1);
      next_seq_r <= SEQ_BITS'(1);
      dup_r      <= '0;
      inflight_r <= '0;
      waiting_r  <= 1'b0;
      head_r     <= '0;
    end else if (acc) begin
      oldest_r   <= oldest_nxt;
      next_seq_r <= next_seq_nxt;
      dup_r      <= dup_nxt;
      inflight_r <= inflight_nxt;
      waiting_r  <= waiting_nxt;
      head_r     <= head_nxt;
    end
  end

  // Payload ring. Every beat reads the head and a send also writes the tail; every write
  // lands at its own accept edge, so a later read never overlaps a pending write.
  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      ring_mem[wr_addr] <= in_ch.payload_word;
    end
    if (acc) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  // ---------------- stage 1 and output buffer ----------------
  res_t push_res;
  logic push;
  logic pop;

  always_comb begin
    push_res = s1_res_r;
    if (s1_mem_r) begin
      push_res.packet_payload = rd_data_r;
    end
  end

  assign push = s1_v_r && !sk_v_r;
  assign pop  = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
      s1_mem_r <= use_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (pop) begin
        out_res_r <= sk_res_r;
        sk_v_r    <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_res_r <= push_res;
        out_v_r   <= 1'b1;
      end else begin
        sk_res_r <= push_res;
        sk_v_r   <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.packet_action  = out_res_r.packet_action;
  assign out_ch.packet_seq     = out_res_r.packet_seq;
  assign out_ch.packet_payload = out_res_r.packet_payload;
  assign out_ch.timer_command  = out_res_r.timer_command;
  assign out_ch.timer_seq      = out_res_r.timer_seq;
  assign out_ch.send_accepted  = out_res_r.send_accepted;
  assign out_ch.window_full    = out_res_r.window_full;

endmodule : sliding_window_sender_fast_retransmit

`default_nettype wire

>>> sv/swfr_checker.sv
// swfr_port_checks: port-level checks on the sliding-window sender's result channel.
// Depends on swfr_pkg; bound to sliding_window_sender_fast_retransmit below.
`default_nettype none

module swfr_port_checks #(
  parameter int unsigned SEQ_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [1:0]              packet_action,
  input wire logic [SEQ_BITS-1:0]     packet_seq,
  input wire logic [PAYLOAD_BITS-1:0] packet_payload,
  input wire logic [1:0]              timer_command,
  input wire logic [SEQ_BITS-1:0]     timer_seq,
  input wire logic                    send_accepted,
  input wire logic                    window_full
);

  // a stalled result beat stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // nothing sent means no sequence and no payload
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && packet_action == swfr_pkg::ACT_NONE |->
      packet_seq == '0 && packet_payload == '0)
    else $error("fields set with no packet sent");

  // an accepted send is a new packet and leaves the window not full
  a_send_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_accepted |-> packet_action == swfr_pkg::ACT_NEW && !window_full)
    else $error("accepted send not reported as new packet");

  // a retransmission always restarts the timer for the same packet
  a_retx_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && packet_action == swfr_pkg::ACT_RETX |->
      timer_command == swfr_pkg::TMR_RESTART && timer_seq == packet_seq && !send_accepted)
    else $error("retransmission without timer restart");

  // no timer command means no timer sequence
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timer_command == swfr_pkg::TMR_NONE |-> timer_seq == '0)
    else $error("timer sequence set with no command");

endmodule : swfr_port_checks

bind sliding_window_sender_fast_retransmit swfr_port_checks #(
  .SEQ_BITS(SEQ_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_swfr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .packet_action (out_ch.packet_action),
  .packet_seq    (out_ch.packet_seq),
  .packet_payload(out_ch.packet_payload),
  .timer_command (out_ch.timer_command),
  .timer_seq     (out_ch.timer_seq),
  .send_accepted (out_ch.send_accepted),
  .window_full   (out_ch.window_full)
);

`default_nettype wire

>>> dv/swfr_checker.sv
// swfr_checker: watches the channels and the config port of the sliding-window sender,
// predicts every result beat and compares it field by field.
// Depends on swfr_pkg and the channel interfaces swfr_in_if / swfr_out_if.
`timescale 1ns / 100ps

module swfr_checker #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  swfr_in_if                          in_ch,
  swfr_out_if                         out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [swfr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [swfr_pkg::APB_DW-1:0] cfg_pwdata,
  input  logic                        cfg_pready,
  output int                          fails,
  output int                          owed,
  output logic [15:0]                 base_seq,
  output logic [15:0]                 send_seq,
  output int                          n_checked,
  output int                          n_retx,
  output int                          n_refused
);

  localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] seq;
    logic [31:0] payload;
    logic [1:0]  tcmd;
    logic [15:0] tseq;
    logic        accepted;
    logic        full;
  } tx_result_t;

  tx_result_t expected_tx[$];

  // predicted sender state
  logic [swfr_pkg::WIN_W-1:0] win;
  logic [15:0]                oldest;
  logic [15:0]                nxt;
  logic [swfr_pkg::DUP_W-1:0] dup_cnt;
  int unsigned                flight;
  logic                       stalled;
  int unsigned                head;
  logic [31:0]                ring [MAX_WINDOW];

  function automatic tx_result_t retransmit_oldest();
    tx_result_t r;
    r         = '0;
    r.action  = swfr_pkg::ACT_RETX;
    r.seq     = oldest;
    r.payload = ring[IW'(head)];
    r.tcmd    = swfr_pkg::TMR_RESTART;
    r.tseq    = oldest;
    return r;
  endfunction

  function automatic tx_result_t advance_window(logic [1:0] f, logic [31:0] pw,
                                                logic [15:0] an, logic good);
    tx_result_t  r;
    int unsigned room;
    logic [15:0] ack_off;
    logic [15:0] prev;
    r       = '0;
    room    = (32'(win) > MAX_WINDOW) ? MAX_WINDOW : 32'(win);
    ack_off = an - oldest;
    case (f)
      swfr_pkg::FUNC_SEND: begin
        if (flight < room) begin
          ring[IW'((head + flight) % MAX_WINDOW)] = pw;
          stalled    = 1'b0;
          r.action   = swfr_pkg::ACT_NEW;
          r.seq      = nxt;
          r.payload  = pw;
          r.accepted = 1'b1;
          if (flight == 0) begin
            r.tcmd = swfr_pkg::TMR_START;
            r.tseq = nxt;
          end
          flight++;
          nxt++;
        end else begin
          stalled = 1'b1;
          n_refused++;
        end
      end
      swfr_pkg::FUNC_ACK: begin
        if (flight != 0 && good && 32'(ack_off) <= flight) begin
          if (ack_off == 0) begin
            dup_cnt++;
            if (dup_cnt == swfr_pkg::DUP_LIMIT) begin
              // fast retransmit
              r       = retransmit_oldest();
              dup_cnt = '0;
            end else if (dup_cnt == swfr_pkg::DUP_ONE) begin
              r.tcmd = swfr_pkg::TMR_RESTART;
              r.tseq = oldest;
            end
          end else begin
            prev    = oldest;
            dup_cnt = swfr_pkg::DUP_ONE;
            oldest  = an;
            flight  = flight - 32'(ack_off);
            head    = (head + 32'(ack_off)) % MAX_WINDOW;
            if (flight == 0) begin
              r.tcmd = swfr_pkg::TMR_STOP;
              r.tseq = prev;
            end else begin
              r.tcmd = swfr_pkg::TMR_RESTART;
              r.tseq = oldest;
            end
          end
        end
      end
      swfr_pkg::FUNC_TIMEOUT: begin
        if (flight != 0) r = retransmit_oldest();
      end
      default: ;
    endcase
    if (r.action == swfr_pkg::ACT_RETX) n_retx++;
    r.full = stalled;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    tx_result_t want;
    if (!rst_n) begin
      win     = swfr_pkg::WIN_RESET;
      oldest  = 16'd1;
      nxt     = 16'd1;
      dup_cnt = '0;
      flight  = 0;
      stalled = 1'b0;
      head    = 0;
      expected_tx.delete();
      fails     = 0;
      n_checked = 0;
      n_retx    = 0;
      n_refused = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[2] == swfr_pkg::REG_WIN_LIMIT)
        win = cfg_pwdata[swfr_pkg::WIN_W-1:0];
      if (in_ch.valid && in_ch.ready)
        expected_tx.push_back(advance_window(in_ch.func, in_ch.payload_word,
                                             in_ch.ack_number, in_ch.ack_checksum_good));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_tx.size() == 0) begin
          $error("result beat with nothing expected (action %0d, seq 0x%0h)",
                 out_ch.packet_action, out_ch.packet_seq);
          fails++;
        end else begin
          want = expected_tx.pop_front();
          n_checked++;
          check_field("packet_action", 32'(want.action), 32'(out_ch.packet_action));
          check_field("packet_seq", 32'(want.seq), 32'(out_ch.packet_seq));
          check_field("packet_payload", want.payload, out_ch.packet_payload);
          check_field("timer_command", 32'(want.tcmd), 32'(out_ch.timer_command));
          check_field("timer_seq", 32'(want.tseq), 32'(out_ch.timer_seq));
          check_field("send_accepted", 32'(want.accepted), 32'(out_ch.send_accepted));
          check_field("window_full", 32'(want.full), 32'(out_ch.window_full));
        end
      end
    end
    owed     = expected_tx.size();
    base_seq = oldest;
    send_seq = nxt;
  end

endmodule : swfr_checker

>>> dv/tb_top.sv
// tb_top: stimulus and verdict for the sliding-window sender with fast retransmit.
// Drives send/ack/timeout beats and APB window writes; swfr_checker predicts and compares.
// Depends on swfr_pkg, swfr_in_if.sv, the block and dv/swfr_checker.sv.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIMIT     = 2000;  // quiet cycles before the watchdog gives up
  localparam int LONG_HOLD = 90;    // receiver hold-off, far longer than the output buffer
  localparam int SETTLE    = 4;     // margin after the last owed result is taken
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [swfr_pkg::APB_AW-1:0] ADDR_WINDOW = {swfr_pkg::REG_WIN_LIMIT, 2'b00};

  // what kind of beat to offer; ack values are worked out from the live window
  typedef enum {
    K_SEND, K_SEND_ZERO, K_SEND_ONES, K_ACK_DUP, K_ACK_IN, K_ACK_ALL, K_ACK_PARTIAL,
    K_ACK_BEYOND, K_ACK_BAD, K_ACK_RAND, K_TIMEOUT, K_UNUSED
  } item_kind_t;

  logic clk;
  logic rst_n;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  swfr_in_if  in_ch ();
  swfr_out_if out_ch ();

  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [swfr_pkg::APB_AW-1:0] cfg_paddr;
  logic [swfr_pkg::APB_DW-1:0] cfg_pwdata;
  logic [swfr_pkg::APB_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  int          fails;
  int          owed;
  logic [15:0] base_seq;
  logic [15:0] send_seq;
  int          n_checked;
  int          n_retx;
  int          n_refused;

  sliding_window_sender_fast_retransmit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  swfr_checker i_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fails       (fails),
    .owed        (owed),
    .base_seq    (base_seq),
    .send_seq    (send_seq),
    .n_checked   (n_checked),
    .n_retx      (n_retx),
    .n_refused   (n_refused)
  );

  // sender pacing and pressure control
  int burst_left;
  bit gaps_on;
  int hold_requests;
  int dup_left;
  int beats_sent;
  int settings_done;

  // Receiver: segments of free flow, random stalls and a fixed stall rhythm. A long
  // hold-off is served whenever the stimulus raises hold_requests.
  initial begin
    int served;
    int hold;
    int seg_left;
    int mode;
    served   = 0;
    hold     = 0;
    seg_left = 0;
    mode     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        hold   = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(5, 40);
        end
        seg_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (seg_left % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: any beat or register access counts as progress.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results still owed", LIMIT, owed);
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one beat. Fields are chosen after the gap, at the falling edge, so the
  // window seen through the checker already holds every earlier accepted beat.
  task automatic issue(input item_kind_t kind);
    int          gap;
    logic [15:0] flight;
    logic [1:0]  f;
    logic [31:0] pw;
    logic [15:0] an;
    logic        g;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    flight = send_seq - base_seq;
    f  = swfr_pkg::FUNC_ACK;
    pw = $urandom;
    an = 16'($urandom);
    g  = 1'b1;
    case (kind)
      K_SEND:        f = swfr_pkg::FUNC_SEND;
      K_SEND_ZERO: begin
        f  = swfr_pkg::FUNC_SEND;
        pw = '0;
      end
      K_SEND_ONES: begin
        f  = swfr_pkg::FUNC_SEND;
        pw = '1;
      end
      K_ACK_DUP:     an = base_seq;
      K_ACK_IN:      an = base_seq + 16'($urandom_range(0, flight));
      K_ACK_ALL:     an = send_seq;
      // slide but keep something in flight where possible
      K_ACK_PARTIAL: an = base_seq + ((flight > 1) ? 16'($urandom_range(1, flight - 1)) : flight);
      K_ACK_BEYOND:  an = send_seq + 16'($urandom_range(1, 16'h7FFF));
      K_ACK_BAD: begin
        an = base_seq + 16'($urandom_range(0, flight));
        g  = 1'b0;
      end
      K_ACK_RAND:    g = 1'($urandom_range(0, 1));
      K_TIMEOUT:     f = swfr_pkg::FUNC_TIMEOUT;
      default: begin
        f = FUNC_UNUSED;
        g = 1'($urandom_range(0, 1));
      end
    endcase
    in_ch.func              <= f;
    in_ch.payload_word      <= pw;
    in_ch.ack_number        <= an;
    in_ch.ack_checksum_good <= g;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Sender stops and waits for every owed result, then lets the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [swfr_pkg::APB_AW-1:0] addr,
                           input logic [swfr_pkg::APB_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // window size write with junk above the register's five bits
  task automatic set_window(input int unsigned w);
    drain();
    write_reg(ADDR_WINDOW, {(swfr_pkg::APB_DW - swfr_pkg::WIN_W)'($urandom),
                            swfr_pkg::WIN_W'(w)});
    settings_done++;
  endtask

  function automatic item_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 36) return K_SEND;
    if (r == 36) return K_SEND_ZERO;
    if (r == 37) return K_SEND_ONES;
    if (r < 56) return K_ACK_IN;
    if (r < 66) return K_ACK_PARTIAL;
    if (r < 72) return K_ACK_ALL;
    if (r < 76) return K_ACK_DUP;
    if (r < 80) return K_ACK_BEYOND;
    if (r < 84) return K_ACK_BAD;
    if (r < 88) return K_ACK_RAND;
    if (r < 97) return K_TIMEOUT;
    return K_UNUSED;
  endfunction

  // Opening run at the reset window of 4: ignored timeout/ack/unused code on an empty
  // window, extreme payloads, filling and refusing, four equal acks to a fast
  // retransmit, bad checksum, ack past next, timeout, partial and full slide, then a
  // new ack followed by three equal ones.
  item_kind_t opening [23] = '{
    K_TIMEOUT, K_ACK_IN, K_UNUSED, K_SEND_ZERO, K_SEND_ONES, K_SEND, K_SEND, K_SEND,
    K_ACK_DUP, K_ACK_DUP, K_ACK_DUP, K_ACK_DUP, K_ACK_BAD, K_ACK_BEYOND, K_TIMEOUT,
    K_ACK_PARTIAL, K_ACK_ALL, K_SEND, K_SEND, K_ACK_PARTIAL, K_ACK_DUP, K_ACK_DUP,
    K_ACK_DUP
  };

  // window settings per random phase; zero and 31 are the refuse-all and clamp cases
  int unsigned windows [9] = '{16, 1, 31, 0, 7, 2, 16, 5, 4};

  initial begin
    item_kind_t k;
    int         n_items;
    rst_n                   = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.func              = swfr_pkg::FUNC_SEND;
    in_ch.payload_word      = '0;
    in_ch.ack_number        = '0;
    in_ch.ack_checksum_good = 1'b0;
    cfg_psel                = 1'b0;
    cfg_penable             = 1'b0;
    cfg_pwrite              = 1'b0;
    cfg_paddr               = '0;
    cfg_pwdata              = '0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    hold_requests = 0;
    dup_left      = 0;
    beats_sent    = 0;
    settings_done = 1;
    windows[7]    = $urandom_range(1, 16);

    // reset held over the first rising edges, released at the next falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) issue(opening[i]);

    foreach (windows[p]) begin
      set_window(windows[p]);
      // first phase: back-to-back beats into a long receiver hold-off
      gaps_on = (p != 0);
      if (p == 0) hold_requests++;
      n_items = (windows[p] == 0) ? 25 : 115;
      repeat (n_items) begin
        if (dup_left > 0) begin
          dup_left--;
          issue(K_ACK_DUP);
        end else begin
          k = pick_kind();
          if (k == K_ACK_DUP) dup_left = $urandom_range(2, 4);
          if ($urandom_range(0, 99) == 0) drain();
          issue(k);
        end
      end
    end

    drain();
    $display("Covered %0d beats over %0d window settings (0 to 31), one %0d-cycle hold-off.",
             beats_sent, settings_done, LONG_HOLD);
    $display("%0d results checked: %0d retransmissions, %0d refused sends.",
             n_checked, n_retx, n_refused);
    if (fails == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule : tb_top

>>> sim.f
sv/swfr_pkg.sv
sv/swfr_in_if.sv
sv/sliding_window_sender_fast_retransmit.sv
sv/swfr_checker.sv
dv/swfr_checker.sv
dv/tb_top.sv
